>>> rtl/core/kerq_pkg.sv
// Shared types and constants for the key event retransmit queue.
// Used by the controller, the datapath and the top level; depends on nothing.
package kerq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;

  localparam logic [15:0] DEF_ACK_TIMEOUT_MS = 16'd300;
  localparam logic [3:0]  DEF_MAX_ATTEMPTS   = 4'd5;

  localparam logic REG_ACK_TIMEOUT = 1'b0;
  localparam logic REG_MAX_ATTEMPTS = 1'b1;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_POLL    = 2'd1,
    OP_CLEAR   = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_ORDINARY = 2'd0,
    KIND_CMD      = 2'd1,
    KIND_ALT      = 2'd2,
    KIND_CTRL     = 2'd3
  } key_kind_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_DROPPED  = 3'd1,
    EV_ACK_OK   = 3'd2,
    EV_ACK_REJ  = 3'd3,
    EV_GIVE_UP  = 3'd4
  } event_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ACK,
    S_TIMER,
    S_WAIT,
    S_SEND,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [31:0] request;
    logic        control;
    logic        option;
    logic        shift;
    logic        cmd;
    logic        press;
    logic [7:0]  key_code;
  } entry_t;

  typedef struct packed {
    logic latch;
    logic enq;
    logic clr;
    logic ack;
    logic timer;
    logic send;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    empty;
    logic    last_one;
    logic    ack_hit;
    logic    due;
    logic    give_up;
  } status_t;

endpackage

>>> rtl/core/kerq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module kerq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/core/kerq_ctrl.sv
// Sequencing state machine of the key event retransmit queue.
// Depends on kerq_pkg; drives the datapath through command and status structs.
module kerq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              res_valid,
  input  logic              res_ready,
  input  kerq_pkg::status_t status,
  output kerq_pkg::cmd_t    cmd
);

  import kerq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (status.op)
          OP_POLL: state_next = status.empty ? S_RESULT : S_ACK;
          default: state_next = S_RESULT;
        endcase
      end
      S_ACK: begin
        if (status.ack_hit) begin
          state_next = status.last_one ? S_RESULT : S_WAIT;
        end else begin
          state_next = S_TIMER;
        end
      end
      S_TIMER: begin
        if (!status.due) begin
          state_next = S_RESULT;
        end else if (status.give_up) begin
          state_next = status.last_one ? S_RESULT : S_WAIT;
        end else begin
          state_next = S_SEND;
        end
      end
      S_WAIT:   state_next = S_SEND;
      S_SEND:   state_next = S_RESULT;
      S_RESULT: begin
        if (res_ready) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    res_valid = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        cmd.latch = req_valid;
      end
      S_DECODE: begin
        cmd.enq = (status.op == OP_ENQUEUE);
        cmd.clr = (status.op == OP_CLEAR);
      end
      S_ACK:    cmd.ack = 1'b1;
      S_TIMER:  cmd.timer = 1'b1;
      S_WAIT:   cmd = '0;
      S_SEND:   cmd.send = 1'b1;
      S_RESULT: res_valid = 1'b1;
      default:  cmd = '0;
    endcase
  end

endmodule

>>> rtl/core/kerq_dp.sv
// Datapath of the key event retransmit queue: ring pointers, request numbering,
// acknowledgment and timeout checks, result registers. Depends on kerq_pkg and kerq_ram.
module kerq_dp #(
  parameter int QUEUE_DEPTH = kerq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  kerq_pkg::cmd_t                     cmd,
  output kerq_pkg::status_t                  status,
  input  logic [15:0]                        ack_timeout_ms,
  input  logic [3:0]                         max_attempts,
  input  logic [1:0]                         opcode,
  input  logic [7:0]                         key_code,
  input  logic [1:0]                         key_kind,
  input  logic                               cmd_flag,
  input  logic                               shift_flag,
  input  logic                               option_flag,
  input  logic                               control_flag,
  input  logic                               is_press,
  input  logic [31:0]                        now_ms,
  input  logic [31:0]                        ack_revision,
  input  logic [31:0]                        ack_request,
  input  logic                               ack_accepted,
  output logic [2:0]                         event_res,
  output logic                               transmit,
  output logic [7:0]                         tx_key_code,
  output logic                               tx_press,
  output logic                               tx_cmd,
  output logic                               tx_shift,
  output logic                               tx_option,
  output logic                               tx_control,
  output logic [31:0]                        tx_request,
  output logic [3:0]                         tx_attempt,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   queue_level
);

  import kerq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [IDX_W-1:0] head_index;
  logic [CNT_W-1:0] fill_count;
  logic [31:0]      last_request;
  logic [31:0]      seen_revision;
  logic [3:0]       head_attempts;
  logic [31:0]      head_sent_time;

  logic [1:0]  lat_opcode;
  logic [7:0]  lat_key_code;
  logic [1:0]  lat_kind;
  logic        lat_cmd;
  logic        lat_shift;
  logic        lat_option;
  logic        lat_control;
  logic        lat_press;
  logic [31:0] lat_now;
  logic [31:0] lat_rev;
  logic [31:0] lat_ack_req;
  logic        lat_accepted;

  event_t res_event;

  entry_t           rd_entry;
  entry_t           wr_entry;
  logic             wr_en;
  logic [CNT_W:0]   tail_sum;
  logic [CNT_W:0]   tail_wrap;
  logic [IDX_W-1:0] tail_index;
  logic [IDX_W-1:0] head_inc;
  logic             full;
  logic [31:0]      request_inc;
  logic [31:0]      request_next;
  logic [3:0]       limit;
  logic [31:0]      elapsed;
  logic             rev_new;
  logic             ack_hit;
  logic             due;
  logic             give_up;
  logic             drop;
  key_kind_t        kind;

  kerq_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_index),
    .wr_data (wr_entry),
    .rd_addr (head_index),
    .rd_data (rd_entry)
  );

  always_comb begin
    kind      = key_kind_t'(lat_kind);
    tail_sum  = (CNT_W+1)'(head_index) + (CNT_W+1)'(fill_count);
    tail_wrap = (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH)) ?
                tail_sum - (CNT_W+1)'(QUEUE_DEPTH) : tail_sum;
    tail_index = tail_wrap[IDX_W-1:0];
    head_inc   = (head_index == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_index + IDX_W'(1);
    full       = (fill_count == CNT_W'(QUEUE_DEPTH));

    request_inc  = last_request + 32'd1;
    request_next = (request_inc == 32'd0) ? 32'd1 : request_inc;

    wr_entry.request  = request_next;
    wr_entry.key_code = lat_key_code;
    wr_entry.press    = lat_press;
    wr_entry.shift    = lat_shift;
    wr_entry.cmd      = lat_cmd & ~(~lat_press & (kind == KIND_CMD));
    wr_entry.option   = lat_option & ~(~lat_press & (kind == KIND_ALT));
    wr_entry.control  = lat_control & ~(~lat_press & (kind == KIND_CTRL));
    wr_en             = cmd.enq & ~full;

    limit   = (max_attempts == 4'd0) ? 4'd1 : max_attempts;
    elapsed = lat_now - head_sent_time;
    rev_new = (lat_rev != seen_revision);
    ack_hit = rev_new && (lat_ack_req == rd_entry.request);
    due     = (head_attempts == 4'd0) || (elapsed >= {16'd0, ack_timeout_ms});
    give_up = (head_attempts >= limit);
    drop    = (cmd.ack && ack_hit) || (cmd.timer && due && give_up);

    status.op       = opcode_t'(lat_opcode);
    status.empty    = (fill_count == '0);
    status.last_one = (fill_count == CNT_W'(1));
    status.ack_hit  = ack_hit;
    status.due      = due;
    status.give_up  = give_up;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_index     <= '0;
      fill_count     <= '0;
      last_request   <= '0;
      seen_revision  <= '0;
      head_attempts  <= '0;
      head_sent_time <= '0;
    end else begin
      if (wr_en) begin
        fill_count   <= fill_count + CNT_W'(1);
        last_request <= request_next;
      end
      if (cmd.clr) begin
        head_index    <= '0;
        fill_count    <= '0;
        head_attempts <= '0;
        seen_revision <= lat_rev;
      end
      if (cmd.ack && rev_new) begin
        seen_revision <= lat_rev;
      end
      if (drop) begin
        head_index    <= head_inc;
        fill_count    <= fill_count - CNT_W'(1);
        head_attempts <= '0;
      end
      if (cmd.send) begin
        head_attempts  <= head_attempts + 4'd1;
        head_sent_time <= lat_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      lat_opcode   <= opcode;
      lat_key_code <= key_code;
      lat_kind     <= key_kind;
      lat_cmd      <= cmd_flag;
      lat_shift    <= shift_flag;
      lat_option   <= option_flag;
      lat_control  <= control_flag;
      lat_press    <= is_press;
      lat_now      <= now_ms;
      lat_rev      <= ack_revision;
      lat_ack_req  <= ack_request;
      lat_accepted <= ack_accepted;
      res_event    <= EV_NONE;
      transmit     <= 1'b0;
      tx_key_code  <= '0;
      tx_press     <= 1'b0;
      tx_cmd       <= 1'b0;
      tx_shift     <= 1'b0;
      tx_option    <= 1'b0;
      tx_control   <= 1'b0;
      tx_request   <= '0;
      tx_attempt   <= '0;
    end
    if (cmd.enq && full) begin
      res_event <= EV_DROPPED;
    end
    if (cmd.ack && ack_hit) begin
      res_event <= lat_accepted ? EV_ACK_OK : EV_ACK_REJ;
    end
    if (cmd.timer && due && give_up) begin
      res_event <= EV_GIVE_UP;
    end
    if (cmd.send) begin
      transmit    <= 1'b1;
      tx_key_code <= rd_entry.key_code;
      tx_press    <= rd_entry.press;
      tx_cmd      <= rd_entry.cmd;
      tx_shift    <= rd_entry.shift;
      tx_option   <= rd_entry.option;
      tx_control  <= rd_entry.control;
      tx_request  <= rd_entry.request;
      tx_attempt  <= head_attempts + 4'd1;
    end
  end

  assign event_res   = res_event;
  assign queue_level = fill_count;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(QUEUE_DEPTH))
    else $error("ring fill count exceeds depth");

  a_send_nonzero_request: assert property (@(posedge clk) disable iff (rst)
    cmd.send |=> (tx_request != 32'd0) && (head_attempts != 4'd0))
    else $error("transmission with zero request number or attempt count");

  a_ack_pops_head: assert property (@(posedge clk) disable iff (rst)
    (cmd.ack && ack_hit) |=> fill_count == $past(fill_count) - CNT_W'(1))
    else $error("matching acknowledgment did not pop the head");
`endif

endmodule

>>> rtl/core/key_event_retransmit_queue.sv
// Key event retransmit queue: stop-and-wait delivery of key events with timeout resend.
// Enqueue, clear and a poll of an empty ring give their result after decode; any other poll
// checks the acknowledgment, then the timeout, and may pop the head, wait for the registered
// ring read and send the head. The next request is taken the cycle after the result is taken.
// Synchronous active-high reset empties the ring and restores timeout 300 and 5 attempts.
// Depends on kerq_pkg, kerq_ctrl, kerq_dp and kerq_ram.
module key_event_retransmit_queue #(
  parameter int QUEUE_DEPTH = kerq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  logic [1:0]                       opcode,
  input  logic [7:0]                       key_code,
  input  logic [1:0]                       key_kind,
  input  logic                             cmd_flag,
  input  logic                             shift_flag,
  input  logic                             option_flag,
  input  logic                             control_flag,
  input  logic                             is_press,
  input  logic [31:0]                      now_ms,
  input  logic [31:0]                      ack_revision,
  input  logic [31:0]                      ack_request,
  input  logic                             ack_accepted,
  output logic                             res_valid,
  input  logic                             res_ready,
  output logic [2:0]                       event_res,
  output logic                             transmit,
  output logic [7:0]                       tx_key_code,
  output logic                             tx_press,
  output logic                             tx_cmd,
  output logic                             tx_shift,
  output logic                             tx_option,
  output logic                             tx_control,
  output logic [31:0]                      tx_request,
  output logic [3:0]                       tx_attempt,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_level
);

  import kerq_pkg::*;

  logic [15:0] ack_timeout_ms;
  logic [3:0]  max_attempts;
  logic        cfg_write;
  cmd_t        cmd;
  status_t     status;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout_ms <= DEF_ACK_TIMEOUT_MS;
      max_attempts   <= DEF_MAX_ATTEMPTS;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_ACK_TIMEOUT:  ack_timeout_ms <= pwdata[15:0];
        REG_MAX_ATTEMPTS: max_attempts   <= pwdata[3:0];
        default:          max_attempts   <= max_attempts;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ACK_TIMEOUT:  prdata = {16'd0, ack_timeout_ms};
      REG_MAX_ATTEMPTS: prdata = {28'd0, max_attempts};
      default:          prdata = '0;
    endcase
  end

  kerq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .status    (status),
    .cmd       (cmd)
  );

  kerq_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .ack_timeout_ms (ack_timeout_ms),
    .max_attempts   (max_attempts),
    .opcode         (opcode),
    .key_code       (key_code),
    .key_kind       (key_kind),
    .cmd_flag       (cmd_flag),
    .shift_flag     (shift_flag),
    .option_flag    (option_flag),
    .control_flag   (control_flag),
    .is_press       (is_press),
    .now_ms         (now_ms),
    .ack_revision   (ack_revision),
    .ack_request    (ack_request),
    .ack_accepted   (ack_accepted),
    .event_res      (event_res),
    .transmit       (transmit),
    .tx_key_code    (tx_key_code),
    .tx_press       (tx_press),
    .tx_cmd         (tx_cmd),
    .tx_shift       (tx_shift),
    .tx_option      (tx_option),
    .tx_control     (tx_control),
    .tx_request     (tx_request),
    .tx_attempt     (tx_attempt),
    .queue_level    (queue_level)
  );

endmodule
